@@ rtl/core/lcdw_pkg.sv @@
package lcdw_pkg;

    // one input item
    typedef struct packed {
        logic [7:0] lcd_byte;
        logic       command;
    } t_in_item;

    // one bus symbol
    typedef struct packed {
        logic [1:0] symbol_kind;
        logic       sda_level;
        logic       last;
    } t_out_item;

    // address byte followed by the four expander bytes, first byte in the top bits
    localparam int FRAME_BYTES = 5;
    localparam int FRAME_W     = 8 * FRAME_BYTES;
    typedef logic [FRAME_W-1:0] t_frame;

    localparam logic [1:0] SYM_START = 2'd0;
    localparam logic [1:0] SYM_BIT   = 2'd1;
    localparam logic [1:0] SYM_ACK   = 2'd2;
    localparam logic [1:0] SYM_STOP  = 2'd3;

    localparam logic [7:0] XP_BACKLIGHT = 8'h08;
    localparam logic [7:0] XP_ENABLE    = 8'h04;
    localparam logic [7:0] XP_RS        = 8'h01;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 7;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_ADDRESS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACKLIGHT_ON   = 2'd1;

    localparam logic [6:0] RST_DEVICE_ADDRESS = 7'h27;
    localparam logic       RST_BACKLIGHT_ON   = 1'b1;

    // bit slot counter: 0..7 data bits, then the ack slot
    localparam int BIT_CNT_W = 4;
    localparam logic [BIT_CNT_W-1:0] ACK_SLOT = 4'd8;
    localparam int BYTE_CNT_W = $clog2(FRAME_BYTES);
    localparam logic [BYTE_CNT_W-1:0] LAST_BYTE = BYTE_CNT_W'(FRAME_BYTES - 1);

endpackage

@@ rtl/core/lcdw_front.sv @@
module lcdw_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lcdw_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [lcdw_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  lcdw_pkg::t_in_item                  i_item,
    output lcdw_pkg::t_frame                    o_frame
);

    logic [6:0] r_device_address;
    logic       r_backlight_on;
    logic [7:0] ctrl;
    logic [7:0] hi;
    logic [7:0] lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_address <= lcdw_pkg::RST_DEVICE_ADDRESS;
            r_backlight_on   <= lcdw_pkg::RST_BACKLIGHT_ON;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lcdw_pkg::CFG_DEVICE_ADDRESS: r_device_address <= i_cfg_data[6:0];
                lcdw_pkg::CFG_BACKLIGHT_ON:   r_backlight_on   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        ctrl = (i_item.command ? lcdw_pkg::XP_RS : 8'h00)
             | (r_backlight_on ? lcdw_pkg::XP_BACKLIGHT : 8'h00);
        hi   = {i_item.lcd_byte[7:4], 4'h0};
        lo   = {i_item.lcd_byte[3:0], 4'h0};
        // each nibble goes out with enable high, then again with enable low
        o_frame = {r_device_address, 1'b0,
                   hi | ctrl | lcdw_pkg::XP_ENABLE,
                   hi | ctrl,
                   lo | ctrl | lcdw_pkg::XP_ENABLE,
                   lo | ctrl};
    end

endmodule

@@ rtl/core/lcdw_fifo.sv @@
module lcdw_fifo #(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  lcdw_pkg::t_frame  i_wr_data,
    input  logic              i_rd,
    output lcdw_pkg::t_frame  o_rd_data,
    output logic              o_full,
    output logic              o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    lcdw_pkg::t_frame r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_wr;
    logic             do_rd;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign do_wr     = i_wr && !o_full;
    assign do_rd     = i_rd && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/lcdw_back.sv @@
module lcdw_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lcdw_pkg::t_frame     i_frame,
    input  logic                 i_frame_empty,
    output logic                 o_frame_pop,
    output lcdw_pkg::t_out_item  o_item,
    output logic                 o_empty,
    input  logic                 i_pop
);

    localparam logic [1:0] ST_START = 2'd0;
    localparam logic [1:0] ST_DATA  = 2'd1;
    localparam logic [1:0] ST_STOP  = 2'd2;

    logic [1:0]                          r_state;
    logic [1:0]                          n_state;
    lcdw_pkg::t_frame                    r_shift;
    lcdw_pkg::t_frame                    n_shift;
    logic [lcdw_pkg::BIT_CNT_W-1:0]      r_bit;
    logic [lcdw_pkg::BIT_CNT_W-1:0]      n_bit;
    logic [lcdw_pkg::BYTE_CNT_W-1:0]     r_byte;
    logic [lcdw_pkg::BYTE_CNT_W-1:0]     n_byte;
    logic                                r_out_valid;
    logic                                n_out_valid;
    lcdw_pkg::t_out_item                 r_out;
    lcdw_pkg::t_out_item                 n_out;
    logic                                advance;
    logic                                emit;

    // output register frees up when empty or when its symbol is taken
    assign advance     = !r_out_valid || i_pop;
    assign emit        = advance && ((r_state != ST_START) || !i_frame_empty);
    assign o_frame_pop = emit && (r_state == ST_START);
    assign o_item      = r_out;
    assign o_empty     = !r_out_valid;

    always_comb begin
        n_state = r_state;
        n_shift = r_shift;
        n_bit   = r_bit;
        n_byte  = r_byte;
        n_out   = r_out;
        case (r_state)
            ST_START: begin
                n_out   = '{symbol_kind: lcdw_pkg::SYM_START, sda_level: 1'b0, last: 1'b0};
                n_shift = i_frame;
                n_bit   = '0;
                n_byte  = '0;
                n_state = ST_DATA;
            end
            ST_DATA: begin
                if (r_bit == lcdw_pkg::ACK_SLOT) begin
                    n_out = '{symbol_kind: lcdw_pkg::SYM_ACK, sda_level: 1'b1, last: 1'b0};
                    n_bit = '0;
                    if (r_byte == lcdw_pkg::LAST_BYTE) begin
                        n_state = ST_STOP;
                    end else begin
                        n_byte = r_byte + 1'b1;
                    end
                end else begin
                    n_out   = '{symbol_kind: lcdw_pkg::SYM_BIT,
                                sda_level: r_shift[lcdw_pkg::FRAME_W-1], last: 1'b0};
                    n_shift = {r_shift[lcdw_pkg::FRAME_W-2:0], 1'b0};
                    n_bit   = r_bit + 1'b1;
                end
            end
            ST_STOP: begin
                n_out   = '{symbol_kind: lcdw_pkg::SYM_STOP, sda_level: 1'b1, last: 1'b1};
                n_state = ST_START;
            end
            default: begin
                n_state = ST_START;
            end
        endcase
    end

    always_comb begin
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_shift <= n_shift;
            r_out   <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_START;
            r_bit       <= '0;
            r_byte      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (emit) begin
                r_state <= n_state;
                r_bit   <= n_bit;
                r_byte  <= n_byte;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_last_only_on_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.last |-> r_out.symbol_kind == lcdw_pkg::SYM_STOP)
        else $error("last flag on a symbol other than stop");

    a_counters_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit <= lcdw_pkg::ACK_SLOT && r_byte <= lcdw_pkg::LAST_BYTE)
        else $error("bit or byte counter out of range");

    a_stop_then_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && r_state == ST_STOP |=> r_state == ST_START && r_out.last)
        else $error("stop symbol not followed by wait for next frame");

    a_frame_boundary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_STOP || r_state == ST_START |-> r_bit == '0)
        else $error("frame ended in the middle of a byte");

    a_start_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_frame_pop |=> r_out_valid && r_out.symbol_kind == lcdw_pkg::SYM_START)
        else $error("frame taken without a start symbol");
`endif

endmodule

@@ rtl/core/i2c_char_lcd_byte_writer.sv @@
// character-LCD byte writer for an HD44780 in 4-bit mode behind an I2C port expander
// input side is a queue: present i_item and raise push while full is low; each
// transfer carries one display byte and the instruction/data flag
// result side is a queue: while empty is low, o_item holds the oldest bus symbol,
// raise pop to take it
// every item turns into one I2C write of 47 symbols: start, address byte with
// write bit, four expander bytes, each followed by an ack slot, then stop
// an item is queued as a frame; the back end registers its start symbol on taking it
// symbols come out one per cycle while pop is held high; the bit serializer in the
// back end sets that rate, and when the next frame is already queued, its start
// follows the previous stop with no gap
// a small frame queue (FIFO_DEPTH entries) sits between the byte builder and the
// serializer, so items keep being taken while symbols drain
// when pop stays low the serializer holds its symbol and stops, the frame queue
// fills, and then full rises
// synchronous reset empties both queues and restores address 0x27 and backlight on
// registers: index 0 device_address, index 1 backlight_on, others are ignored
module i2c_char_lcd_byte_writer #(
    parameter int FIFO_DEPTH = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lcdw_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [lcdw_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              push,
    output logic                              full,
    input  lcdw_pkg::t_in_item                i_item,
    output logic                              empty,
    input  logic                              pop,
    output lcdw_pkg::t_out_item               o_item
);

    lcdw_pkg::t_frame front_frame;
    lcdw_pkg::t_frame queue_frame;
    logic             queue_empty;
    logic             queue_pop;

    lcdw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_item),
        .o_frame     (front_frame)
    );

    lcdw_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (push),
        .i_wr_data (front_frame),
        .i_rd      (queue_pop),
        .o_rd_data (queue_frame),
        .o_full    (full),
        .o_empty   (queue_empty)
    );

    lcdw_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame       (queue_frame),
        .i_frame_empty (queue_empty),
        .o_frame_pop   (queue_pop),
        .o_item        (o_item),
        .o_empty       (empty),
        .i_pop         (pop)
    );

endmodule
